>>> design/smoothed_gain_ramp_core_assert.svh
// assertion helpers shared by the gain ramp design
`ifndef SMOOTHED_GAIN_RAMP_CORE_ASSERT_SVH
`define SMOOTHED_GAIN_RAMP_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SGR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SGR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sgr_pkg.sv
`timescale 1ns / 1ps
package sgr_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;

    localparam int SMP_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int FRAC_EXTRA = 16;
    localparam int ACC_W      = GAIN_W + FRAC_EXTRA;
    localparam int STEP_W     = ACC_W + 1;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = $clog2(ACC_W);
    localparam int PROD_W     = SMP_W + GAIN_W + 1;
    localparam int QFRAC      = 20;
    localparam int Q_W        = PROD_W - QFRAC;

    localparam logic [GAIN_W-1:0] UNITY_GAIN   = GAIN_W'(1 << QFRAC);
    localparam logic [LEN_W-1:0]  RAMP_DEFAULT = LEN_W'(2400);

    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [SMP_W-1:0] sample_ch0;
        logic signed [SMP_W-1:0] sample_ch1;
        logic [GAIN_W-1:0]       new_gain;
    } in_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_ch0;
        logic signed [SMP_W-1:0] out_ch1;
        logic                    clipped;
    } out_item_t;

    typedef struct packed {
        logic                     start;
        logic signed [STEP_W-1:0] dividend;
        logic [LEN_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [STEP_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                    en;
        logic signed [SMP_W-1:0] sample;
        logic [GAIN_W-1:0]       gain;
    } scale_req_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    clip;
    } scale_rsp_t;

endpackage

>>> design/sgr_div.sv
`timescale 1ns / 1ps
module sgr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sgr_pkg::div_req_t req,
    output sgr_pkg::div_rsp_t rsp
);
    import sgr_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;
    logic [ACC_W-1:0]  quo_reg, quo_next;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    trial_sub;
    logic              fits;
    logic [STEP_W-1:0] mag;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[ACC_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        mag       = req.dividend[STEP_W-1] ? STEP_W'(-req.dividend) : req.dividend;

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;

        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.dividend[STEP_W-1];
            cnt_next  = CNT_W'(ACC_W - 1);
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = mag[ACC_W-1:0];
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // quotient truncates toward zero
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

>>> design/sgr_scale.sv
`timescale 1ns / 1ps
module sgr_scale (
    input  logic                aclk,
    input  sgr_pkg::scale_req_t req,
    output sgr_pkg::scale_rsp_t rsp
);
    import sgr_pkg::*;

    localparam longint SAT_HI     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO     = -SAT_HI - 64'sd1;
    localparam int     ROUND_HALF = 1 << (QFRAC - 1);

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [Q_W-1:0]    q;

    assign prod_next = req.sample * $signed({1'b0, req.gain});

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= prod_next;
        end
    end

    // round half up, then clamp to the sample range
    always_comb begin
        rnd = prod_reg + PROD_W'(ROUND_HALF);
        q   = rnd[PROD_W-1:QFRAC];
        if (longint'(q) > SAT_HI) begin
            rsp.value = SAT_HI[SMP_W-1:0];
            rsp.clip  = 1'b1;
        end else if (longint'(q) < SAT_LO) begin
            rsp.value = SAT_LO[SMP_W-1:0];
            rsp.clip  = 1'b1;
        end else begin
            rsp.value = q[SMP_W-1:0];
            rsp.clip  = 1'b0;
        end
    end

endmodule

>>> design/smoothed_gain_ramp_core.sv
`timescale 1ns / 1ps
// sample frame: the single shared multiplier takes the two channels in turn (S_MUL0, S_MUL1),
//   then S_FIN loads the output register once it is free; no new item is taken until then
// set target with a ramp: S_TGT starts the 40-step shift-subtract divider for the step, S_DIV waits for it
// set target without a ramp, cancel, unused kind: no result
// aresetn is synchronous, active low: unity gain, no ramp, ramp length 2400, output empty
`include "smoothed_gain_ramp_core_assert.svh"
module smoothed_gain_ramp_core (
    input  logic               aclk,
    input  logic               aresetn,
    // input transactions
    input  logic               s_valid,
    output logic               s_ready,
    input  sgr_pkg::in_item_t  s_data,
    // result transactions
    output logic               m_valid,
    input  logic               m_ready,
    output sgr_pkg::out_item_t m_data,
    // ramp length register
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_ramp_samples
);
    import sgr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGT,
        S_DIV,
        S_MUL0,
        S_MUL1,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [LEN_W-1:0]         ramp_samples_reg, ramp_samples_next;
    logic [GAIN_W-1:0]        target_reg, target_next;
    logic [ACC_W-1:0]         gain_acc_reg, gain_acc_next;
    logic signed [STEP_W-1:0] ramp_step_reg, ramp_step_next;
    logic [LEN_W-1:0]         ramp_left_reg, ramp_left_next;

    // frame working registers
    logic signed [SMP_W-1:0]  smp0_reg, smp0_next;
    logic signed [SMP_W-1:0]  smp1_reg, smp1_next;
    logic signed [SMP_W-1:0]  res0_reg, res0_next;
    logic                     clip0_reg, clip0_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic [ACC_W-1:0]         target_wide;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    scale_req_t               scale_req;
    scale_rsp_t               scale_rsp;

    // short terms for the checks below
    logic                     frame_accept;
    logic                     last_step;
    logic                     acc_on_target;

    sgr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sgr_scale u_scale (
        .aclk (aclk),
        .req  (scale_req),
        .rsp  (scale_rsp)
    );

    // target gain widened to the accumulator format
    assign target_wide = {target_reg, {FRAC_EXTRA{1'b0}}};

    // new transactions only between items; the output register decouples the result side
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign frame_accept  = s_valid && s_ready && (s_data.kind == KIND_FRAME);
    assign last_step     = (ramp_left_reg == LEN_W'(1));
    assign acc_on_target = (gain_acc_reg == target_wide);

    always_comb begin
        state_next        = state_reg;
        ramp_samples_next = cfg_valid ? cfg_ramp_samples : ramp_samples_reg;
        target_next       = target_reg;
        gain_acc_next     = gain_acc_reg;
        ramp_step_next    = ramp_step_reg;
        ramp_left_next    = ramp_left_reg;
        smp0_next         = smp0_reg;
        smp1_next         = smp1_reg;
        res0_next         = res0_reg;
        clip0_next        = clip0_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        div_req           = '0;
        scale_req.en      = 1'b0;
        scale_req.sample  = smp0_reg;
        scale_req.gain    = gain_acc_reg[ACC_W-1:FRAC_EXTRA];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.kind)
                        KIND_FRAME: begin
                            smp0_next  = s_data.sample_ch0;
                            smp1_next  = s_data.sample_ch1;
                            // advance the ramp before the multiply
                            if (ramp_left_reg != '0) begin
                                ramp_left_next = ramp_left_reg - LEN_W'(1);
                                if (ramp_left_reg == LEN_W'(1)) begin
                                    // last step lands exactly on the target
                                    gain_acc_next  = target_wide;
                                    ramp_step_next = '0;
                                end else begin
                                    gain_acc_next = gain_acc_reg + ramp_step_reg[ACC_W-1:0];
                                end
                            end
                            state_next = S_MUL0;
                        end
                        KIND_TARGET: begin
                            target_next = s_data.new_gain;
                            state_next  = S_TGT;
                        end
                        KIND_CANCEL: begin
                            gain_acc_next  = target_wide;
                            ramp_step_next = '0;
                            ramp_left_next = '0;
                        end
                        default: begin
                            // unused kind, dropped
                        end
                    endcase
                end
            end
            S_TGT: begin
                if (gain_acc_reg == target_wide || ramp_samples_reg == '0) begin
                    // already there or no ramp wanted: jump and stop any ramp
                    gain_acc_next  = target_wide;
                    ramp_step_next = '0;
                    ramp_left_next = '0;
                    state_next     = S_IDLE;
                end else begin
                    ramp_left_next   = ramp_samples_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = $signed({1'b0, target_wide} - {1'b0, gain_acc_reg});
                    div_req.divisor  = ramp_samples_reg;
                    state_next       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    ramp_step_next = div_rsp.quotient;
                    state_next     = S_IDLE;
                end
            end
            S_MUL0: begin
                scale_req.en     = 1'b1;
                scale_req.sample = smp0_reg;
                state_next       = S_MUL1;
            end
            S_MUL1: begin
                // left product is ready while the right one is issued
                scale_req.en     = 1'b1;
                scale_req.sample = smp1_reg;
                res0_next        = scale_rsp.value;
                clip0_next       = scale_rsp.clip;
                state_next       = S_FIN;
            end
            S_FIN: begin
                // hold here while the previous result is still waiting
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.out_ch0 = res0_reg;
                    m_data_next.out_ch1 = (CHANNELS > 1) ? scale_rsp.value : '0;
                    m_data_next.clipped = clip0_reg || ((CHANNELS > 1) && scale_rsp.clip);
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        smp0_reg   <= smp0_next;
        smp1_reg   <= smp1_next;
        res0_reg   <= res0_next;
        clip0_reg  <= clip0_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            ramp_samples_reg <= RAMP_DEFAULT;
            target_reg       <= UNITY_GAIN;
            gain_acc_reg     <= {UNITY_GAIN, {FRAC_EXTRA{1'b0}}};
            ramp_step_reg    <= '0;
            ramp_left_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            ramp_samples_reg <= ramp_samples_next;
            target_reg       <= target_next;
            gain_acc_reg     <= gain_acc_next;
            ramp_step_reg    <= ramp_step_next;
            ramp_left_reg    <= ramp_left_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // no step may linger once the ramp count is exhausted
    `SGR_ASSERT_IMP(a_step_without_ramp, ramp_left_reg == '0, ramp_step_reg == '0, "stray step")
    // the divider only answers while the sequencer waits for it
    `SGR_ASSERT_IMP(a_div_done_state, div_rsp.done, state_reg == S_DIV, "divider done outside wait")
    // a frame goes straight to the multiplier
    `SGR_ASSERT_NXT(a_frame_to_mul, frame_accept, state_reg == S_MUL0, "frame skipped multiply")
    // the last ramp step snaps to the target
    `SGR_ASSERT_NXT(a_ramp_snap, frame_accept && last_step, acc_on_target, "ramp missed target")
    // results are only loaded from the finish step
    `SGR_ASSERT_IMP(a_result_source, $rose(m_valid), $past(state_reg == S_FIN), "result not from finish")

endmodule
